// File: rtl/core/assert_macros.svh
// assertion macros used by the checker file of this block
// depends on nothing; each macro takes a label, clock, disable term and the property terms
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/u8s_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and byte classification for the utf-8 sanitizer
// no dependencies

package u8s_pkg;

   // replacement byte for malformed input
   localparam logic [7:0] REPL_BYTE = 8'h5F;

   // result pattern of the item under work
   typedef logic [2:0] kind_type;
   localparam kind_type KIND_NONE      = 3'd0;  // lead, held continuation or dropped byte
   localparam kind_type KIND_PASS      = 3'd1;  // ascii while idle
   localparam kind_type KIND_REPL_PASS = 3'd2;  // ascii inside a sequence
   localparam kind_type KIND_REPL      = 3'd3;  // stray continuation
   localparam kind_type KIND_FLUSH     = 3'd4;  // final continuation of a sequence

   // controller to datapath commands
   typedef struct packed {
      logic load_item;
      logic emit;
      logic finish;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic no_result;
      logic last_step;
      logic out_free;
   } status_type;

   // count of leading one bits of a byte, 0 to 8
   function automatic logic [3:0] lead_ones(input logic [7:0] b);
      logic [3:0] n;
      logic       run;
      n   = 4'd0;
      run = 1'b1;
      for (int i = 7; i >= 0; i--) begin
         if (run && b[i]) begin
            n = n + 4'd1;
         end else begin
            run = 1'b0;
         end
      end
      return n;
   endfunction

endpackage

// File: rtl/core/u8s_ctrl.sv
`timescale 1ns / 1ps
// controller for the utf-8 sanitizer: item intake and result sequencing
// depends on u8s_pkg for the command and status structs

module u8s_ctrl
   import u8s_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic state_ff;
   logic state_in;

   // command decode
   always_comb begin
      cmd.emit   = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.emit   = 1'b0;
            cmd.finish = 1'b0;
         end
         ST_EMIT: begin
            cmd.emit   = status.out_free && !status.no_result;
            cmd.finish = status.no_result || (status.out_free && status.last_step);
         end
         default: begin
            cmd.emit   = 1'b0;
            cmd.finish = 1'b0;
         end
      endcase
      req_tready    = (state_ff == ST_IDLE) || cmd.finish;
      cmd.load_item = req_tvalid && req_tready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      if (cmd.load_item) begin
         state_in = ST_EMIT;
      end else if (cmd.finish) begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/u8s_datapath.sv
`timescale 1ns / 1ps
// datapath for the utf-8 sanitizer: sequence state, held bytes, result mux, output register
// depends on u8s_pkg for types, constants and lead_ones

module u8s_datapath
   import u8s_pkg::*;
#(
   parameter int MAX_SEQ_LEN = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_tdata,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_tvalid,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast,
   input  logic       rsp_tready
);

   localparam int HELD_DEPTH = MAX_SEQ_LEN - 1;
   localparam int IDX_W      = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;

   logic [7:0] cur_byte_ff, cur_byte_in;
   logic [2:0] rem_ff, rem_in;
   logic [2:0] len_ff, len_in;
   logic [2:0] step_ff, step_in;
   logic [7:0] held_ff [HELD_DEPTH];
   logic [7:0] held_in [HELD_DEPTH];
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;

   logic [3:0] ones;
   logic       is_lead;
   kind_type   kind;
   logic [2:0] n_results;
   logic [7:0] res_byte;
   logic       hold_we;
   logic [2:0] hold_idx;
   logic       out_free;

   // classify the item under work against the sequence state
   always_comb begin
      ones    = lead_ones(cur_byte_ff);
      is_lead = (ones >= 4'd2) && (ones <= 4'(MAX_SEQ_LEN));
      kind    = KIND_NONE;
      if (ones == 4'd0) begin
         kind = (rem_ff != 3'd1) ? KIND_REPL_PASS : KIND_PASS;
      end else if (ones == 4'd1) begin
         if (rem_ff > 3'd1) begin
            kind = (rem_ff == 3'd2) ? KIND_FLUSH : KIND_NONE;
         end else begin
            kind = KIND_REPL;
         end
      end
   end

   // result count and byte at the current step
   always_comb begin
      case (kind)
         KIND_PASS: begin
            n_results = 3'd1;
            res_byte  = cur_byte_ff;
         end
         KIND_REPL_PASS: begin
            n_results = 3'd2;
            res_byte  = (step_ff == 3'd0) ? REPL_BYTE : cur_byte_ff;
         end
         KIND_REPL: begin
            n_results = 3'd1;
            res_byte  = REPL_BYTE;
         end
         KIND_FLUSH: begin
            n_results = len_ff;
            res_byte  = (step_ff == len_ff - 3'd1) ? cur_byte_ff
                                                   : held_ff[step_ff[IDX_W-1:0]];
         end
         default: begin
            n_results = 3'd0;
            res_byte  = cur_byte_ff;
         end
      endcase
   end

   assign out_free         = !rsp_valid_ff || rsp_tready;
   assign status.no_result = (n_results == 3'd0);
   assign status.last_step = (step_ff + 3'd1 == n_results);
   assign status.out_free  = out_free;

   // sequence state update when the item finishes
   always_comb begin
      rem_in   = rem_ff;
      len_in   = len_ff;
      hold_we  = 1'b0;
      hold_idx = 3'd0;
      if (cmd.finish) begin
         if (ones == 4'd0) begin
            rem_in = 3'd1;
         end else if (ones == 4'd1) begin
            if (rem_ff > 3'd1) begin
               rem_in   = rem_ff - 3'd1;
               hold_we  = (rem_ff != 3'd2);
               hold_idx = len_ff - (rem_ff - 3'd1);
            end else begin
               rem_in = 3'd1;
            end
         end else if (is_lead) begin
            rem_in   = ones[2:0];
            len_in   = ones[2:0];
            hold_we  = 1'b1;
            hold_idx = 3'd0;
         end
      end
   end

   // held byte store
   always_comb begin
      held_in = held_ff;
      if (hold_we && (hold_idx < 3'(HELD_DEPTH))) begin
         held_in[hold_idx[IDX_W-1:0]] = cur_byte_ff;
      end
   end

   // item register and step counter
   always_comb begin
      cur_byte_in = cmd.load_item ? req_tdata : cur_byte_ff;
      step_in     = step_ff;
      if (cmd.load_item) begin
         step_in = 3'd0;
      end else if (cmd.emit) begin
         step_in = step_ff + 3'd1;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = res_byte;
         rsp_last_in  = status.last_step;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= 3'd1;
         len_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_byte_ff <= cur_byte_in;
      step_ff     <= step_in;
      held_ff     <= held_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: rtl/core/utf8_sanitizer_stream.sv
`timescale 1ns / 1ps
// utf8_sanitizer_stream: byte-serial utf-8 sanitizer, '_' replaces malformed parts
//
// req channel takes one raw byte per item; rsp channel gives sanitized bytes, with
// tlast high on the final result byte caused by an input item. ascii passes through,
// multibyte sequences of 2 to MAX_SEQ_LEN bytes are held and emitted whole on their
// final continuation, stray continuations give '_', an ascii byte that cuts a sequence
// gives '_' then the byte, and 0xFE, 0xFF and over-long leads are dropped.
// an accepted item goes to the item register, and its first result is loaded into
// the output register once that register is free. throughput: items with zero or one
// result can stream at one per cycle while the output is free; results leave through
// the single output register, one result byte per cycle while the receiver takes them.
// a new item is taken in the cycle the previous one issues its last result, and an
// item may be taken while that last result still waits in the output register.
// when the receiver stalls the output register holds its byte and an item with results
// still to give waits; req_tready stays low until its last result is loaded.
// reset (synchronous, active high) clears the sequence state to idle and empties
// the output register; held bytes need no clearing.
// depends on u8s_pkg, u8s_ctrl and u8s_datapath

module utf8_sanitizer_stream
   import u8s_pkg::*;
#(
   parameter int MAX_SEQ_LEN = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast
);

   cmd_type    cmd;
   status_type status;

   // item intake and result sequencing
   u8s_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // sequence state and result path
   u8s_datapath #(
      .MAX_SEQ_LEN (MAX_SEQ_LEN)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tready (rsp_tready)
   );

endmodule

// File: rtl/core/u8s_checker.sv
`timescale 1ns / 1ps
// port-level checks for utf8_sanitizer_stream, attached by bind
// depends on assert_macros.svh and the top level's ports
`include "assert_macros.svh"

module u8s_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // a stalled result holds its byte and marker
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // results of one item follow back to back once the receiver takes them
   `ASSERT_NEXT(a_burst_gapless, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid)

   // intake only stalls while results are being produced
   `ASSERT_NEXT(a_stall_has_output, clock, reset, !req_tready, rsp_tvalid)

   // output register is empty right after reset
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind utf8_sanitizer_stream u8s_checker u_u8s_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// File: bench/tb.sv
`timescale 1ns / 1ps
// self-checking bench for utf8_sanitizer_stream: byte stream in, sanitized bytes out
// depends on u8s_pkg and the utf8_sanitizer_stream rtl

module tb;
   import u8s_pkg::*;

   localparam int MAX_SEQ     = 6;
   localparam int HELD_N      = MAX_SEQ - 1;
   localparam int RANDOM_N    = 225;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_N    = 20;
   localparam int RX_HOLD_N   = 300;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } clean_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] in_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic       rsp_tlast;

   // raw bytes waiting to be sent and sanitized bytes waiting to arrive
   logic [7:0]     raw_q[$];
   clean_byte_type clean_q[$];

   // shadow of the sanitizer's sequence state
   logic [2:0] seq_left = 3'd1;
   logic [2:0] seq_len = 3'd0;
   logic [7:0] held[HELD_N];

   int  cycle_count = 0;
   int  sent_count = 0;
   int  fail_count = 0;
   int  stim_count = 0;
   int  directed_n = 0;
   bit  req_fire = 1'b0;
   int  burst_left = 0;
   int  gap_left = 0;
   int  rx_hold_left = 0;
   bit  rx_hold_done = 1'b0;
   int  rx_mode = 0;
   int  rx_phase_left = 0;
   int  rx_pat = 0;

   utf8_sanitizer_stream #(
      .MAX_SEQ_LEN(MAX_SEQ)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // work out the sanitized bytes one raw byte gives and queue them
   function automatic void sanitize_byte(input logic [7:0] b);
      int         ones;
      logic [7:0] outs[$];
      ones = 0;
      casez (b)
         8'b0???????: ones = 0;
         8'b10??????: ones = 1;
         8'b110?????: ones = 2;
         8'b1110????: ones = 3;
         8'b11110???: ones = 4;
         8'b111110??: ones = 5;
         8'b1111110?: ones = 6;
         default:     ones = 7;   // 0xfe and 0xff
      endcase
      if (ones == 0) begin
         // ascii, cutting any open sequence
         if (seq_left != 3'd1) begin
            outs.push_back(REPL_BYTE);
            seq_left = 3'd1;
         end
         outs.push_back(b);
      end else if (ones == 1) begin
         if (seq_left > 3'd1) begin
            seq_left = seq_left - 3'd1;
            if (seq_left == 3'd1) begin
               // final continuation releases the whole sequence
               for (int k = 0; k + 1 < int'(seq_len) && k < HELD_N; k++) begin
                  outs.push_back(held[k]);
               end
               outs.push_back(b);
            end else begin
               held[seq_len - seq_left] = b;
            end
         end else begin
            // stray continuation
            outs.push_back(REPL_BYTE);
            seq_left = 3'd1;
         end
      end else if (ones <= MAX_SEQ) begin
         // new lead drops whatever was open
         seq_left = 3'(ones);
         seq_len  = 3'(ones);
         held[0]  = b;
      end
      for (int k = 0; k < outs.size(); k++) begin
         clean_q.push_back('{data: outs[k], last: (k == outs.size() - 1)});
      end
   endfunction

   // lead byte of an n-byte form with random payload bits
   function automatic logic [7:0] make_lead(input int n);
      logic [7:0] ones_mask;
      logic [7:0] pay_mask;
      ones_mask = 8'hFF << (8 - n);
      pay_mask  = (8'h80 >> n) - 8'd1;
      return ones_mask | (8'($urandom) & pay_mask);
   endfunction

   function automatic logic [7:0] make_cont();
      return 8'h80 | (8'($urandom) & 8'h3F);
   endfunction

   task automatic queue_byte(input logic [7:0] b);
      raw_q.push_back(b);
      if (b < 8'hFE) begin
         stim_count++;
      end
   endtask

   // sender: bursts and gaps, keeps offering during the long receiver hold,
   // pauses until drained after the directed part and once later on
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fire) begin
         // item still offered, hold it
      end else if (raw_q.size() == 0 ||
                   ((sent_count == directed_n || sent_count == directed_n + 200) &&
                    clean_q.size() != 0)) begin
         req_tvalid <= 1'b0;
      end else if (rx_hold_left > 0) begin
         req_tvalid <= 1'b1;
         req_tdata  <= raw_q[0];
      end else if (gap_left > 0) begin
         gap_left--;
         req_tvalid <= 1'b0;
      end else begin
         req_tvalid <= 1'b1;
         req_tdata  <= raw_q[0];
         if (burst_left > 1) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         end
      end
   end

   // receiver: stall modes that change at random intervals, plus one long hold
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_tready <= 1'b0;
      end else if (!rx_hold_done && sent_count >= directed_n + 80) begin
         rx_hold_done = 1'b1;
         rx_hold_left = RX_HOLD_N;
         rsp_tready <= 1'b0;
      end else begin
         if (rx_phase_left == 0) begin
            rx_mode       = $urandom_range(0, 3);
            rx_phase_left = $urandom_range(20, 80);
         end
         rx_phase_left--;
         rx_pat++;
         case (rx_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            2:       rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ((rx_pat % 5) < 2);
         endcase
      end
   end

   // monitor: take accepted bytes into the shadow state, check delivered bytes
   always @(posedge clock) begin
      clean_byte_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end else begin
         req_fire = 1'b0;
         if (!reset) begin
            if (req_tvalid && req_tready) begin
               req_fire = 1'b1;
               sanitize_byte(req_tdata);
               void'(raw_q.pop_front());
               sent_count++;
            end
            if (rsp_tvalid && rsp_tready) begin
               if (clean_q.size() == 0) begin
                  $error("unexpected item: out_byte %h last %b", rsp_tdata, rsp_tlast);
                  fail_count++;
               end else begin
                  want = clean_q.pop_front();
                  if (rsp_tdata !== want.data) begin
                     $error("out_byte mismatch: expected %h, actual %h", want.data, rsp_tdata);
                     fail_count++;
                  end
                  if (rsp_tlast !== want.last) begin
                     $error("last mismatch: expected %b, actual %b", want.last, rsp_tlast);
                     fail_count++;
                  end
               end
            end
         end
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      logic [7:0] directed[$];
      int         n;
      int         kind;
      directed = '{
         8'h00, 8'h7F, 8'h80, 8'hBF, 8'hFE, 8'hFF,
         // two-byte form
         8'hC2, 8'hA9,
         // ascii cutting a three-byte form
         8'hE2, 8'h41,
         // four-byte form with 0xfe dropped in the middle
         8'hF0, 8'h9F, 8'hFE, 8'h98, 8'h80,
         // new lead dropping an open form, then a five-byte form
         8'hC3, 8'hF8, 8'h88, 8'h80, 8'h80, 8'h80,
         // six-byte form
         8'hFC, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF
      };
      foreach (directed[i]) begin
         raw_q.push_back(directed[i]);
      end
      directed_n = raw_q.size();

      // mostly well-formed sequences, some noise and broken ones
      while (stim_count < RANDOM_N) begin
         kind = $urandom_range(0, 9);
         if (kind <= 6) begin
            n = $urandom_range(1, MAX_SEQ);
            if (n == 1) begin
               queue_byte(8'($urandom_range(0, 127)));
            end else begin
               queue_byte(make_lead(n));
               for (int k = 1; k < n; k++) begin
                  queue_byte(make_cont());
               end
            end
         end else if (kind == 7) begin
            queue_byte(8'($urandom_range(0, 255)));
         end else if (kind == 8) begin
            n = $urandom_range(2, MAX_SEQ);
            queue_byte(make_lead(n));
            for (int k = $urandom_range(0, n - 2); k > 0; k--) begin
               queue_byte(make_cont());
            end
         end else begin
            queue_byte(8'hFE | 8'($urandom_range(0, 1)));
         end
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (raw_q.size() != 0 || clean_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_N) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/u8s_pkg.sv
rtl/core/u8s_ctrl.sv
rtl/core/u8s_datapath.sv
rtl/core/utf8_sanitizer_stream.sv
rtl/core/u8s_checker.sv
bench/tb.sv
